// ===== src/frcs_pkg.sv =====
// Shared constants, types and CRC table for the flash region CRC scrubber.
package frcs_pkg;

    localparam int CRC_W   = 32;
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 25;
    localparam int CFG_IDX_W = 2;

    localparam logic [CRC_W-1:0]   CRC_POLY = 32'hEDB88320;
    localparam logic [CRC_W-1:0]   CRC_INIT = 32'hFFFFFFFF;
    localparam logic [COUNT_W-1:0] MAX_REGION_BYTES = 25'd16777216;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GOLDEN_CRC  = 2'd1;

    typedef logic [CRC_W-1:0] crc_table_t [256];

    // Live configuration as seen by the CRC core
    typedef struct packed {
        logic [COUNT_W-1:0] region_size;
        logic [CRC_W-1:0]   golden_crc;
    } cfg_t;

    // One entry of the reflected CRC-32 byte table
    function automatic logic [CRC_W-1:0] crc_table_entry(input int unsigned idx);
        logic [CRC_W-1:0] c;
        c = CRC_W'(idx);
        for (int b = 0; b < BYTE_W; b++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic crc_table_t build_crc_table();
        crc_table_t t;
        for (int i = 0; i < 256; i++) begin
            t[i] = crc_table_entry(i);
        end
        return t;
    endfunction

    localparam crc_table_t CRC_TABLE = build_crc_table();

endpackage

// ===== src/frcs_cfg_regs.sv =====
// Configuration register file for the scrubber.
module frcs_cfg_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    input  logic [frcs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [frcs_pkg::CRC_W-1:0]        cfg_data,
    output frcs_pkg::cfg_t                    cfg
);

    logic [frcs_pkg::COUNT_W-1:0] region_size_reg;
    logic [frcs_pkg::CRC_W-1:0]   golden_crc_reg;

    // Take a write request; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_size_reg <= frcs_pkg::COUNT_W'(1);
            golden_crc_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                frcs_pkg::CFG_REGION_SIZE:
                    region_size_reg <= cfg_data[frcs_pkg::COUNT_W-1:0];
                frcs_pkg::CFG_GOLDEN_CRC:
                    golden_crc_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    assign cfg.region_size = region_size_reg;
    assign cfg.golden_crc  = golden_crc_reg;

endmodule

// ===== src/frcs_crc_core.sv =====
// Running CRC-32 and byte count with pass completion check.
module frcs_crc_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  frcs_pkg::cfg_t                 cfg,
    input  logic                           byte_valid,
    input  logic [frcs_pkg::BYTE_W-1:0]    byte_in,
    output logic                           res_valid,
    output logic [frcs_pkg::CRC_W-1:0]     res_crc,
    output logic                           res_corrupt
);

    logic [frcs_pkg::CRC_W-1:0]   crc_reg, crc_next;
    logic [frcs_pkg::COUNT_W-1:0] done_reg, done_next;
    logic [frcs_pkg::COUNT_W-1:0] pass_len;
    logic [frcs_pkg::COUNT_W-1:0] count;
    logic [frcs_pkg::CRC_W-1:0]   folded;
    logic [frcs_pkg::BYTE_W-1:0]  tbl_idx;
    logic                         active;
    logic                         pass_end;

    // Clamp the region size into one to the maximum
    always_comb
    begin
        if (cfg.region_size == '0)
            pass_len = frcs_pkg::COUNT_W'(1);
        else if (cfg.region_size > frcs_pkg::MAX_REGION_BYTES)
            pass_len = frcs_pkg::MAX_REGION_BYTES;
        else
            pass_len = cfg.region_size;
    end

    // Fold one byte through the table
    assign tbl_idx = crc_reg[frcs_pkg::BYTE_W-1:0] ^ byte_in;
    assign folded  = frcs_pkg::CRC_TABLE[tbl_idx] ^ (crc_reg >> frcs_pkg::BYTE_W);

    assign active   = byte_valid && (cfg.golden_crc != '0);
    assign count    = done_reg + frcs_pkg::COUNT_W'(1);
    assign pass_end = (count >= pass_len);

    // Advance the state, restart on pass end
    always_comb
    begin
        crc_next  = crc_reg;
        done_next = done_reg;
        if (active)
        begin
            if (pass_end)
            begin
                crc_next  = frcs_pkg::CRC_INIT;
                done_next = '0;
            end
            else
            begin
                crc_next  = folded;
                done_next = count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= frcs_pkg::CRC_INIT;
            done_reg <= '0;
        end
        else
        begin
            crc_reg  <= crc_next;
            done_reg <= done_next;
        end
    end

    assign res_valid   = active && pass_end;
    assign res_crc     = ~folded;
    assign res_corrupt = (~folded != cfg.golden_crc);

endmodule

// ===== src/flash_region_crc_scrubber.sv =====
// Top level of the flash region CRC scrubber: input and result registers.
//
// Takes one region byte per request and keeps a reflected CRC-32 (poly
// 0xEDB88320, start all ones) and a byte count. The byte that completes a
// pass of region_size bytes (0 treated as 1, capped at 2^24) gives one result:
// the inverted CRC on m_tdata and the mismatch-against-golden flag on
// m_tuser; the pass then restarts. A zero golden CRC makes every byte a
// no-op. One byte is taken per cycle unless m_tready back-pressure stalls
// the result register. A byte goes through the input register, the
// combinational table-driven CRC update and the result register. Config
// writes are always ready and change neither the running CRC nor the count.
module flash_region_crc_scrubber (
    input  logic                             clk,
    input  logic                             rst_n,
    // Configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [frcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [frcs_pkg::CRC_W-1:0]       cfg_data,
    // Byte stream in
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] data_byte
    // Result stream out
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,   // [31:0] pass_crc
    output logic                             m_tuser    // [0] corrupt
);

    frcs_pkg::cfg_t cfg;

    logic                          in_valid_reg;
    logic [frcs_pkg::BYTE_W-1:0]   in_byte_reg;
    logic                          out_valid_reg;
    logic [frcs_pkg::CRC_W-1:0]    out_crc_reg;
    logic                          out_corrupt_reg;
    logic                          advance;
    logic                          res_valid;
    logic [frcs_pkg::CRC_W-1:0]    res_crc;
    logic                          res_corrupt;

    assign cfg_ready = 1'b1;

    frcs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Move the held byte on when the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Hold the incoming byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_byte_reg <= s_tdata;
    end

    frcs_crc_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .byte_valid  (advance),
        .byte_in     (in_byte_reg),
        .res_valid   (res_valid),
        .res_crc     (res_crc),
        .res_corrupt (res_corrupt)
    );

    // Load or drain the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= res_valid;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_crc_reg     <= res_crc;
            out_corrupt_reg <= res_corrupt;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_crc_reg;
    assign m_tuser  = out_corrupt_reg;

endmodule
